// File: src/sos_pkg.sv
// Shared request codes, status codes and word types for the set of stacks.
package sos_pkg;

    localparam int VALUE_W = 32;

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;
    localparam logic [1:0] REQ_POP_AT = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ABOVE = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] stack_select;
    } sos_cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } sos_result_t;

endpackage

// File: src/sos_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sos_seq.sv
// Request sequencer: steps one sub-stack per cycle through the fill-count memory.
module sos_seq #(
    parameter int SUB_DEPTH  = 16,
    parameter int NUM_STACKS = 4,
    parameter int DATA_WIDTH = 32,
    localparam int IW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1,
    localparam int CW = $clog2(SUB_DEPTH + 1),
    localparam int AW = (NUM_STACKS * SUB_DEPTH > 1) ? $clog2(NUM_STACKS * SUB_DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sos_pkg::sos_cmd_t           in_cmd,
    input  logic [sos_pkg::VALUE_W-1:0] in_value,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sos_pkg::sos_result_t        res,
    output logic                        cnt_we,
    output logic [IW-1:0]               cnt_waddr,
    output logic [CW-1:0]               cnt_wdata,
    output logic [IW-1:0]               cnt_raddr,
    input  logic [CW-1:0]               cnt_rdata,
    output logic                        elem_we,
    output logic [AW-1:0]               elem_waddr,
    output logic [DATA_WIDTH-1:0]       elem_wdata,
    output logic [AW-1:0]               elem_raddr,
    input  logic [DATA_WIDTH-1:0]       elem_rdata
);

    localparam int SW = (IW > 2) ? IW : 2;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_ELEM  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    sos_pkg::sos_cmd_t           cmd_reg, cmd_next;
    logic [sos_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [IW-1:0]               cur_reg, cur_next;
    sos_pkg::sos_result_t        res_reg, res_next;
    logic [NUM_STACKS-1:0]       valid_reg;

    logic [CW-1:0] count;
    logic [CW-1:0] top_pos;
    logic [IW-1:0] start_idx;
    logic [AW-1:0] base;
    logic [AW-1:0] base_up;
    logic [63:0]   push_ext;
    logic [63:0]   read_ext;

    // A sub-stack whose count was never written holds nothing.
    assign count    = valid_reg[idx_reg] ? cnt_rdata : '0;
    assign top_pos  = count - CW'(1);
    assign base     = AW'(idx_reg) * AW'(SUB_DEPTH);
    assign base_up  = base + AW'(SUB_DEPTH);
    assign push_ext = {32'd0, value_reg};
    assign read_ext = 64'(elem_rdata);

    assign start_idx = (in_cmd.req_type == sos_pkg::REQ_POP_AT) ?
                       IW'(in_cmd.stack_select) : cur_reg;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        value_next = value_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        cnt_we     = 1'b0;
        cnt_waddr  = idx_reg;
        cnt_wdata  = '0;
        cnt_raddr  = idx_reg;
        elem_we    = 1'b0;
        elem_waddr = base + AW'(count);
        elem_wdata = push_ext[DATA_WIDTH-1:0];
        elem_raddr = base + AW'(top_pos);

        unique case (state_reg)
            S_IDLE: begin
                cnt_raddr = start_idx;
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    value_next = in_value;
                    idx_next   = start_idx;
                    if (in_cmd.req_type == sos_pkg::REQ_POP_AT &&
                        SW'(in_cmd.stack_select) > SW'(cur_reg)) begin
                        res_next   = '{value: '0, status: sos_pkg::ST_ABOVE};
                        state_next = S_DONE;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (cmd_reg.req_type == sos_pkg::REQ_PUSH) begin
                    state_next = S_DONE;
                    res_next   = '{value: '0, status: sos_pkg::ST_OK};
                    if (count == CW'(SUB_DEPTH)) begin
                        if (idx_reg == IW'(NUM_STACKS - 1)) begin
                            res_next = '{value: '0, status: sos_pkg::ST_FULL};
                        end else begin
                            // Open the next sub-stack; its old count is discarded.
                            cur_next   = idx_reg + IW'(1);
                            cnt_we     = 1'b1;
                            cnt_waddr  = idx_reg + IW'(1);
                            cnt_wdata  = CW'(1);
                            elem_we    = 1'b1;
                            elem_waddr = base_up;
                        end
                    end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = count + CW'(1);
                        elem_we   = 1'b1;
                    end
                end else if (count == '0) begin
                    if (idx_reg != '0) begin
                        idx_next  = idx_reg - IW'(1);
                        cnt_raddr = idx_reg - IW'(1);
                    end else begin
                        res_next   = '{value: '0, status: sos_pkg::ST_EMPTY};
                        state_next = S_DONE;
                        if (cmd_reg.req_type != sos_pkg::REQ_POP_AT) begin
                            cur_next = idx_reg;
                        end
                    end
                end else begin
                    if (cmd_reg.req_type != sos_pkg::REQ_PEEK) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = top_pos;
                    end
                    if (cmd_reg.req_type != sos_pkg::REQ_POP_AT) begin
                        cur_next = idx_reg;
                    end
                    state_next = S_ELEM;
                end
            end
            S_ELEM: begin
                res_next   = '{value: read_ext[sos_pkg::VALUE_W-1:0], status: sos_pkg::ST_OK};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            if (cnt_we) begin
                valid_reg[cnt_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// File: src/set_of_stacks_with_pop_at.sv
// Top level of the set of stacks: sequencer, count and element memories, output register.
//
// One logical stack made of NUM_STACKS sub-stacks of SUB_DEPTH elements each. Every input
// word is one request (push, pop, peek top, or pop from a chosen sub-stack) and gives
// exactly one result word carrying a value and a status (ok, empty, full, or sub-stack
// above current). The block handles one request at a time and drops s_tready while it
// works. A refused pop-at goes straight to its result; a push passes through the check
// state. A pop, peek or pop-at reads the fill count in the check state, steps down past
// every empty sub-stack it meets, and reads the element when it finds one. That step-down
// runs through the fill-count memory one sub-stack per cycle, and the element comes from
// the registered read port of the element memory. A finished result sits in an output
// register, so the next request is taken while that word waits for m_tready.
// Fill counts come out of reset as zero through one valid bit per sub-stack; there is no
// clearing pass, and the element memory is never cleared.
module set_of_stacks_with_pop_at #(
    parameter int SUB_DEPTH  = 16,
    parameter int NUM_STACKS = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [3:0]  s_tuser,   // [1:0] req_type, [3:2] stack_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [1:0]  m_tuser    // [1:0] result_status
);

    localparam int IW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CW = $clog2(SUB_DEPTH + 1);
    localparam int AW = (NUM_STACKS * SUB_DEPTH > 1) ? $clog2(NUM_STACKS * SUB_DEPTH) : 1;

    sos_pkg::sos_cmd_t    in_cmd;
    sos_pkg::sos_result_t res;
    logic                 res_valid;
    logic                 res_ready;

    logic                  cnt_we;
    logic [IW-1:0]         cnt_waddr;
    logic [CW-1:0]         cnt_wdata;
    logic [IW-1:0]         cnt_raddr;
    logic [CW-1:0]         cnt_rdata;
    logic                  elem_we;
    logic [AW-1:0]         elem_waddr;
    logic [DATA_WIDTH-1:0] elem_wdata;
    logic [AW-1:0]         elem_raddr;
    logic [DATA_WIDTH-1:0] elem_rdata;

    sos_pkg::sos_result_t out_reg;
    logic                 out_valid_reg;

    assign in_cmd = '{req_type: s_tuser[1:0], stack_select: s_tuser[3:2]};

    sos_seq #(
        .SUB_DEPTH  (SUB_DEPTH),
        .NUM_STACKS (NUM_STACKS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (in_cmd),
        .in_value   (s_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cnt_we     (cnt_we),
        .cnt_waddr  (cnt_waddr),
        .cnt_wdata  (cnt_wdata),
        .cnt_raddr  (cnt_raddr),
        .cnt_rdata  (cnt_rdata),
        .elem_we    (elem_we),
        .elem_waddr (elem_waddr),
        .elem_wdata (elem_wdata),
        .elem_raddr (elem_raddr),
        .elem_rdata (elem_rdata)
    );

    // Fill count of each sub-stack.
    sos_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_STACKS)
    ) u_count_ram (
        .clk   (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Elements, one SUB_DEPTH-sized region per sub-stack.
    sos_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_STACKS * SUB_DEPTH)
    ) u_elem_ram (
        .clk   (aclk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    // The output register frees up whenever it is empty or its word is being taken.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.value;
    assign m_tuser  = out_reg.status;

    // A request is never taken back to back: the sequencer leaves idle on every accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while the sequencer was busy");

    // No new request is taken while a finished result still waits for the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("input ready while a result was pending");

    // A pending result that cannot move stays pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid)
        else $error("pending result dropped");

    // Any status other than ok carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == sos_pkg::ST_OK || m_tdata == 32'd0))
        else $error("nonzero value with a failing status");

endmodule
